// File: design/twist_exponential_2d_core_assert.svh
// Assertion macros used by the core design file.
`ifndef TWIST_EXPONENTIAL_2D_CORE_ASSERT_SVH
`define TWIST_EXPONENTIAL_2D_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TEX2D_ASSERT_IMPL(name, ck, rstn, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TEX2D_ASSERT_NEXT(name, ck, rstn, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/tex2d_pkg.sv
package tex2d_pkg;

	// Angle constants in fixed point.
	localparam longint unsigned TWO_PI_Q60 = 64'h6487ED5110B4611A;
	localparam longint unsigned PI_Q60     = 64'h3243F6A8885A308D;
	localparam longint unsigned TP30 = (TWO_PI_Q60 + (64'd1 << 29)) >> 30;
	localparam longint unsigned PI30 = (PI_Q60 + (64'd1 << 29)) >> 30;
	localparam longint unsigned HP30 = PI30 / 2;
	localparam longint unsigned CORDIC_GAIN_Q30 = 64'd652032874;

	// Internal widths, sized for the whole range of the angle format.
	localparam int A_W = 34;   // CORDIC angle and vector
	localparam int D_W = 38;   // magnitude of the rate in Q30
	localparam int R_W = 56;   // divider remainder
	localparam int Q_W = 17;   // quotient bits kept

	typedef struct packed {
		logic signed [15:0] w;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic [15:0]        th;
		logic [D_W-1:0]     dm;
		logic [D_W-1:0]     dabs;
	} red_t;

	typedef struct packed {
		logic signed [A_W-1:0] a;
		logic signed [A_W-1:0] cx;
		logic signed [A_W-1:0] cy;
		logic                  neg;
		logic                  wzero;
		logic                  wneg;
		logic signed [15:0]    vx;
		logic signed [15:0]    vy;
		logic signed [15:0]    theta;
		logic [D_W-1:0]        dabs;
	} cor_t;

	typedef struct packed {
		logic [R_W-1:0]     rx;
		logic [R_W-1:0]     ry;
		logic [Q_W-1:0]     qx;
		logic [Q_W-1:0]     qy;
		logic               ovx;
		logic               ovy;
		logic               negx;
		logic               negy;
		logic               wzero;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [15:0] theta;
		logic [D_W-1:0]     dabs;
	} div_t;

	typedef struct packed {
		logic signed [15:0] disp_x;
		logic signed [15:0] disp_y;
		logic signed [15:0] disp_theta;
		logic               saturated;
	} out_t;

	// 2*pi with fb fraction bits, rounded to nearest.
	function automatic longint unsigned two_pi_q(int fb);
		longint unsigned sh;
		sh = 64'(60 - fb);
		return (TWO_PI_Q60 + (64'd1 << (sh - 64'd1))) >> sh;
	endfunction

	// Number of subtract steps needed to reduce both the output angle and the
	// Q30 angle below one turn.
	function automatic int red_steps(int afb);
		longint unsigned tpf;
		longint unsigned dmax;
		int n;
		tpf = two_pi_q(afb);
		dmax = 64'd32768 << (30 - afb);
		n = 1;
		for (int k = 0; k < 40; k++) begin
			if ((TP30 << k) <= dmax || (tpf << k) <= 64'd32768) begin
				n = k + 1;
			end
		end
		return n;
	endfunction

	// atan(2^-i) in Q30, rounded to nearest.
	function automatic longint unsigned atan_q30(int i);
		longint unsigned t;
		unique case (i)
			0:       t = 64'd843314857;
			1:       t = 64'd497837829;
			2:       t = 64'd263043837;
			3:       t = 64'd133525159;
			4:       t = 64'd67021687;
			5:       t = 64'd33543516;
			6:       t = 64'd16775851;
			7:       t = 64'd8388437;
			8:       t = 64'd4194283;
			9:       t = 64'd2097149;
			31:      t = 64'd1;
			default: t = 64'd1 << (30 - i);
		endcase
		return t;
	endfunction

endpackage

// File: design/tex2d_in_if.sv
interface tex2d_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] angular_rate;
	logic signed [15:0] linear_x;
	logic signed [15:0] linear_y;

	modport source(output valid, angular_rate, linear_x, linear_y, input ready);
	modport sink(input valid, angular_rate, linear_x, linear_y, output ready);
endinterface

// File: design/tex2d_out_if.sv
interface tex2d_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] disp_x;
	logic signed [15:0] disp_y;
	logic signed [15:0] disp_theta;
	logic               saturated;

	modport source(output valid, disp_x, disp_y, disp_theta, saturated, input ready);
	modport sink(input valid, disp_x, disp_y, disp_theta, saturated, output ready);
endinterface

// File: design/twist_exponential_2d_core.sv
// Channel  Role    Word
// twist    sink    angular_rate, linear_x, linear_y
// disp     source  disp_x, disp_y, disp_theta, saturated
//
// One word is taken every cycle while the output queue is not full; each word
// passes through the cell chain: angle reduction, CORDIC iterations, multiply
// and one quotient bit per divider cell. A two-word output queue decouples the
// sides; the chain holds while the queue is full. Reset clears the valid bits
// and the queue count only.
module twist_exponential_2d_core #(
	parameter int ANGLE_FRAC_BITS = 12,
	parameter int CORDIC_STEPS = 16
) (
	input logic        clk,
	input logic        arst_n,
	tex2d_in_if.sink   twist,
	tex2d_out_if.source disp
);
	import tex2d_pkg::*;
	`include "twist_exponential_2d_core_assert.svh"

	localparam int S = 30 - ANGLE_FRAC_BITS;
	localparam longint unsigned TPF = two_pi_q(ANGLE_FRAC_BITS);
	localparam int NRED = red_steps(ANGLE_FRAC_BITS);
	localparam logic signed [39:0] TP30_S = 40'(TP30);
	localparam logic signed [39:0] PI30_S = 40'(PI30);
	localparam logic signed [39:0] HP30_S = 40'(HP30);

	typedef struct packed {
		logic signed [50:0] p1;
		logic signed [50:0] p2;
		logic signed [50:0] p3;
		logic signed [50:0] p4;
		logic               wzero;
		logic               wneg;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [15:0] theta;
		logic [D_W-1:0]     dabs;
	} mul_t;

	typedef struct packed {
		logic signed [51:0] nx;
		logic signed [51:0] ny;
		logic               wzero;
		logic               wneg;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [15:0] theta;
		logic [D_W-1:0]     dabs;
	} sum_t;

	logic en;
	logic push;
	logic pop;
	logic [1:0] cnt_q;
	out_t head_q;
	out_t tail_q;
	out_t res;

	red_t red_w [NRED+1];
	logic red_v [NRED+1];
	cor_t cor_w [CORDIC_STEPS+1];
	logic cor_v [CORDIC_STEPS+1];
	div_t div_w [Q_W+1];
	logic div_v [Q_W+1];

	logic [15:0] wm_in;
	cor_t fold_d;
	logic [15:0] wm_f;
	logic signed [39:0] a_f;
	mul_t mul_d;
	logic signed [A_W-1:0] s_m;
	logic signed [A_W-1:0] c_m;
	logic signed [A_W:0] omc_m;
	div_t prep_d;
	logic [51:0] ax;
	logic [51:0] ay;
	logic [R_W-1:0] lim;
	logic satx;
	logic saty;

	logic fold_v_s1;
	mul_t mul_s2;
	logic mul_v_s2;
	sum_t sum_s3;
	logic sum_v_s3;

	assign en = (cnt_q != 2'd2);
	assign twist.ready = en;

	// Input word into the reduction chain.
	always_comb begin
		wm_in = twist.angular_rate[15] ? 16'(16'd0 - twist.angular_rate) : twist.angular_rate;
		red_w[0].w    = twist.angular_rate;
		red_w[0].vx   = twist.linear_x;
		red_w[0].vy   = twist.linear_y;
		red_w[0].th   = wm_in;
		red_w[0].dm   = D_W'(wm_in) << S;
		red_w[0].dabs = D_W'(wm_in) << S;
		red_v[0] = twist.valid;
	end

	for (genvar j = 0; j < NRED; j++) begin : g_red
		tex2d_red_cell #(.SHIFT(NRED - 1 - j), .TPF_C(TPF)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.up_valid(red_v[j]), .up_word(red_w[j]),
			.dn_valid(red_v[j+1]), .dn_word(red_w[j+1])
		);
	end

	// Signed remainder, fold into [-pi/2, pi/2] and the output angle.
	always_comb begin
		wm_f = red_w[NRED].w[15] ? 16'(16'd0 - red_w[NRED].w) : red_w[NRED].w;
		a_f = red_w[NRED].w[15] ? -$signed(40'(red_w[NRED].dm)) : $signed(40'(red_w[NRED].dm));
		fold_d.neg = 1'b0;
		if (a_f > PI30_S) begin
			a_f = a_f - TP30_S;
		end
		if (a_f < -PI30_S) begin
			a_f = a_f + TP30_S;
		end
		if (a_f > HP30_S) begin
			a_f = a_f - PI30_S;
			fold_d.neg = 1'b1;
		end else if (a_f < -HP30_S) begin
			a_f = a_f + PI30_S;
			fold_d.neg = 1'b1;
		end
		fold_d.a     = A_W'(a_f);
		fold_d.cx    = A_W'(CORDIC_GAIN_Q30);
		fold_d.cy    = '0;
		fold_d.wzero = (red_w[NRED].w == 16'sd0);
		fold_d.wneg  = red_w[NRED].w[15];
		fold_d.vx    = red_w[NRED].vx;
		fold_d.vy    = red_w[NRED].vy;
		fold_d.dabs  = red_w[NRED].dabs;
		if (64'(wm_f) > TPF) begin
			fold_d.theta = red_w[NRED].w[15] ? 16'(16'd0 - red_w[NRED].th) : red_w[NRED].th;
		end else begin
			fold_d.theta = red_w[NRED].w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_v_s1 <= 1'b0;
			mul_v_s2  <= 1'b0;
			sum_v_s3  <= 1'b0;
			div_v[0]  <= 1'b0;
		end else if (en) begin
			fold_v_s1 <= red_v[NRED];
			mul_v_s2  <= cor_v[CORDIC_STEPS];
			sum_v_s3  <= mul_v_s2;
			div_v[0]  <= sum_v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cor_w[0] <= fold_d;
			mul_s2   <= mul_d;
			sum_s3   <= '{
				nx: 52'(mul_s2.p1) - 52'(mul_s2.p2),
				ny: 52'(mul_s2.p3) + 52'(mul_s2.p4),
				wzero: mul_s2.wzero, wneg: mul_s2.wneg,
				vx: mul_s2.vx, vy: mul_s2.vy,
				theta: mul_s2.theta, dabs: mul_s2.dabs
			};
			div_w[0] <= prep_d;
		end
	end

	assign cor_v[0] = fold_v_s1;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		tex2d_cordic_cell #(.IDX(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.up_valid(cor_v[i]), .up_word(cor_w[i]),
			.dn_valid(cor_v[i+1]), .dn_word(cor_w[i+1])
		);
	end

	// sin, 1 - cos and the four products.
	always_comb begin
		s_m = cor_w[CORDIC_STEPS].neg ? -cor_w[CORDIC_STEPS].cy : cor_w[CORDIC_STEPS].cy;
		c_m = cor_w[CORDIC_STEPS].neg ? -cor_w[CORDIC_STEPS].cx : cor_w[CORDIC_STEPS].cx;
		omc_m = (35'sd1 <<< 30) - 35'(c_m);
		mul_d.p1    = cor_w[CORDIC_STEPS].vx * s_m;
		mul_d.p2    = cor_w[CORDIC_STEPS].vy * omc_m;
		mul_d.p3    = cor_w[CORDIC_STEPS].vy * s_m;
		mul_d.p4    = cor_w[CORDIC_STEPS].vx * omc_m;
		mul_d.wzero = cor_w[CORDIC_STEPS].wzero;
		mul_d.wneg  = cor_w[CORDIC_STEPS].wneg;
		mul_d.vx    = cor_w[CORDIC_STEPS].vx;
		mul_d.vy    = cor_w[CORDIC_STEPS].vy;
		mul_d.theta = cor_w[CORDIC_STEPS].theta;
		mul_d.dabs  = cor_w[CORDIC_STEPS].dabs;
	end

	// Magnitudes with the rounding half added, and the overflow check.
	always_comb begin
		ax = sum_s3.nx[51] ? 52'(-sum_s3.nx) : 52'(sum_s3.nx);
		ay = sum_s3.ny[51] ? 52'(-sum_s3.ny) : 52'(sum_s3.ny);
		lim = R_W'(sum_s3.dabs) << Q_W;
		prep_d.rx    = R_W'(ax) + R_W'(sum_s3.dabs >> 1);
		prep_d.ry    = R_W'(ay) + R_W'(sum_s3.dabs >> 1);
		prep_d.ovx   = (prep_d.rx >= lim);
		prep_d.ovy   = (prep_d.ry >= lim);
		prep_d.qx    = '0;
		prep_d.qy    = '0;
		prep_d.negx  = sum_s3.nx[51] != sum_s3.wneg;
		prep_d.negy  = sum_s3.ny[51] != sum_s3.wneg;
		prep_d.wzero = sum_s3.wzero;
		prep_d.vx    = sum_s3.vx;
		prep_d.vy    = sum_s3.vy;
		prep_d.theta = sum_s3.theta;
		prep_d.dabs  = sum_s3.dabs;
	end

	for (genvar j = 0; j < Q_W; j++) begin : g_div
		tex2d_div_cell #(.K(Q_W - 1 - j)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.up_valid(div_v[j]), .up_word(div_w[j]),
			.dn_valid(div_v[j+1]), .dn_word(div_w[j+1])
		);
	end

	// Sign, saturation and the zero-rate case.
	always_comb begin
		satx = div_w[Q_W].ovx ||
			(div_w[Q_W].negx ? (div_w[Q_W].qx > 17'd32768) : (div_w[Q_W].qx > 17'd32767));
		saty = div_w[Q_W].ovy ||
			(div_w[Q_W].negy ? (div_w[Q_W].qy > 17'd32768) : (div_w[Q_W].qy > 17'd32767));
		res.disp_theta = div_w[Q_W].theta;
		if (div_w[Q_W].wzero) begin
			res.disp_x = div_w[Q_W].vx;
			res.disp_y = div_w[Q_W].vy;
			res.saturated = 1'b0;
		end else begin
			if (satx) begin
				res.disp_x = div_w[Q_W].negx ? 16'sh8000 : 16'sh7fff;
			end else begin
				res.disp_x = div_w[Q_W].negx ? 16'(17'd0 - div_w[Q_W].qx) : div_w[Q_W].qx[15:0];
			end
			if (saty) begin
				res.disp_y = div_w[Q_W].negy ? 16'sh8000 : 16'sh7fff;
			end else begin
				res.disp_y = div_w[Q_W].negy ? 16'(17'd0 - div_w[Q_W].qy) : div_w[Q_W].qy[15:0];
			end
			res.saturated = satx || saty;
		end
	end

	// Two-word output queue.
	assign push = en && div_v[Q_W];
	assign pop  = (cnt_q != 2'd0) && disp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= 2'(cnt_q + 2'(push) - 2'(pop));
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (cnt_q == 2'd2) begin
				head_q <= tail_q;
			end else if (push) begin
				head_q <= res;
			end
		end else if (push && cnt_q == 2'd0) begin
			head_q <= res;
		end
		if (push && !pop && cnt_q == 2'd1) begin
			tail_q <= res;
		end
	end

	assign disp.valid      = (cnt_q != 2'd0);
	assign disp.disp_x     = head_q.disp_x;
	assign disp.disp_y     = head_q.disp_y;
	assign disp.disp_theta = head_q.disp_theta;
	assign disp.saturated  = head_q.saturated;

	`TEX2D_ASSERT_IMPL(a_cnt_range, clk, arst_n, 1'b1, cnt_q != 2'd3, "output queue count out of range")
	`TEX2D_ASSERT_NEXT(a_push_shows, clk, arst_n, push && !pop, cnt_q != 2'd0, "pushed word not visible")
	`TEX2D_ASSERT_IMPL(a_sat_extreme, clk, arst_n, disp.valid && disp.saturated, disp.disp_x == 16'sh7fff || disp.disp_x == 16'sh8000 || disp.disp_y == 16'sh7fff || disp.disp_y == 16'sh8000, "saturated word without a clipped value")
endmodule

// File: design/tex2d_red_cell.sv
// One restoring step of the angle reduction: subtracts one turn times 2^SHIFT
// from both the output angle and the Q30 angle where it fits.
module tex2d_red_cell #(
	parameter int SHIFT = 0,
	parameter longint unsigned TPF_C = 25736
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              up_valid,
	input  tex2d_pkg::red_t   up_word,
	output logic              dn_valid,
	output tex2d_pkg::red_t   dn_word
);
	import tex2d_pkg::*;

	localparam longint unsigned DSTEP = TP30 << SHIFT;
	localparam longint unsigned TSTEP = TPF_C << SHIFT;

	red_t nxt;
	logic valid_q;
	red_t word_q;

	// Conditional subtract on both magnitudes.
	always_comb begin
		nxt = up_word;
		if (64'(up_word.dm) >= DSTEP) begin
			nxt.dm = up_word.dm - D_W'(DSTEP);
		end
		if (64'(up_word.th) >= TSTEP) begin
			nxt.th = up_word.th - 16'(TSTEP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_word  = word_q;
endmodule

// File: design/tex2d_cordic_cell.sv
// One rotation-mode CORDIC iteration.
module tex2d_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              up_valid,
	input  tex2d_pkg::cor_t   up_word,
	output logic              dn_valid,
	output tex2d_pkg::cor_t   dn_word
);
	import tex2d_pkg::*;

	localparam logic signed [A_W-1:0] ATAN = A_W'(atan_q30(IDX));

	cor_t nxt;
	logic signed [A_W-1:0] dx;
	logic signed [A_W-1:0] dy;
	logic valid_q;
	cor_t word_q;

	// Rotate toward zero residual angle.
	always_comb begin
		nxt = up_word;
		dx = up_word.cy >>> IDX;
		dy = up_word.cx >>> IDX;
		if (!up_word.a[A_W-1]) begin
			nxt.cx = up_word.cx - dx;
			nxt.cy = up_word.cy + dy;
			nxt.a  = up_word.a - ATAN;
		end else begin
			nxt.cx = up_word.cx + dx;
			nxt.cy = up_word.cy - dy;
			nxt.a  = up_word.a + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_word  = word_q;
endmodule

// File: design/tex2d_div_cell.sv
// One restoring division step for both quotients: quotient bit K.
module tex2d_div_cell #(
	parameter int K = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              up_valid,
	input  tex2d_pkg::div_t   up_word,
	output logic              dn_valid,
	output tex2d_pkg::div_t   dn_word
);
	import tex2d_pkg::*;

	div_t nxt;
	logic [R_W-1:0] step;
	logic valid_q;
	div_t word_q;

	// Compare and subtract the shifted divisor.
	always_comb begin
		nxt = up_word;
		step = R_W'(up_word.dabs) << K;
		if (up_word.rx >= step) begin
			nxt.rx = up_word.rx - step;
			nxt.qx[K] = 1'b1;
		end
		if (up_word.ry >= step) begin
			nxt.ry = up_word.ry - step;
			nxt.qy[K] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_word  = word_q;
endmodule
